/* src/chpi_pkg.sv */
`timescale 1ns / 1ps

package chpi_pkg;

    // field widths fixed by the interface
    localparam int WORD_W      = 64;
    localparam int SIZE_W      = 31;

    // mixer constants: multiply by 0xffffffff is (w << 32) - w modulo 2^64
    localparam int MIX_SHIFT   = 33;
    localparam int MUL_SHIFT   = 32;
    localparam logic [WORD_W-1:0] GOLD = 64'h9e37_79b9_7f4a_7c15;

    // one remainder step per quotient bit
    localparam int DIV_STAGES  = WORD_W;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        MODE_STAR   = 1'b0,
        MODE_GALAXY = 1'b1
    } mode_t;

    // combined hash waiting for reduction
    typedef struct packed {
        logic [WORD_W-1:0] hash;
        logic [SIZE_W-1:0] size;
    } hash_item_t;

    // queue status seen by the front part
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

/* src/chpi_front.sv */
`timescale 1ns / 1ps

module chpi_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           mode,
    input  logic [chpi_pkg::WORD_W-1:0]    x_bits,
    input  logic [chpi_pkg::WORD_W-1:0]    y_bits,
    input  logic [chpi_pkg::SIZE_W-1:0]    table_size,
    input  chpi_pkg::queue_status_t        queue_status,
    output logic                           stall,
    output logic                           out_valid,
    output chpi_pkg::hash_item_t           out_item
);

    function automatic logic [chpi_pkg::WORD_W-1:0] xor_shift(
        input logic [chpi_pkg::WORD_W-1:0] w
    );
        return w ^ (w >> chpi_pkg::MIX_SHIFT);
    endfunction

    function automatic logic [chpi_pkg::WORD_W-1:0] mul_mask(
        input logic [chpi_pkg::WORD_W-1:0] w
    );
        return (w << chpi_pkg::MUL_SHIFT) - w;
    endfunction

    logic                          advance;
    logic                          accept;

    logic                          s1_valid_reg;
    logic                          s1_mode_reg;
    logic [chpi_pkg::WORD_W-1:0]   s1_x_reg;
    logic [chpi_pkg::WORD_W-1:0]   s1_y_reg;
    logic [chpi_pkg::SIZE_W-1:0]   s1_size_reg;

    logic                          s2_valid_reg;
    logic                          s2_mode_reg;
    logic [chpi_pkg::WORD_W-1:0]   s2_x_reg;
    logic [chpi_pkg::WORD_W-1:0]   s2_y_reg;
    logic [chpi_pkg::SIZE_W-1:0]   s2_size_reg;
    logic [chpi_pkg::WORD_W-1:0]   s2_x_next;
    logic [chpi_pkg::WORD_W-1:0]   s2_y_next;

    logic                          s3_valid_reg;
    logic                          s3_mode_reg;
    logic [chpi_pkg::WORD_W-1:0]   s3_x_reg;
    logic [chpi_pkg::WORD_W-1:0]   s3_y_reg;
    logic [chpi_pkg::SIZE_W-1:0]   s3_size_reg;
    logic [chpi_pkg::WORD_W-1:0]   s3_x_next;
    logic [chpi_pkg::WORD_W-1:0]   s3_y_next;

    logic                          out_valid_reg;
    chpi_pkg::hash_item_t          out_item_reg;
    chpi_pkg::hash_item_t          out_item_next;

    assign stall   = out_valid_reg & queue_status.full;
    assign advance = ~stall;
    assign accept  = in_valid & advance;

    always_comb
    begin
        s2_x_next = xor_shift(mul_mask(s1_x_reg));
        s2_y_next = xor_shift(mul_mask(s1_y_reg));
        s3_x_next = xor_shift(mul_mask(s2_x_reg));
        s3_y_next = xor_shift(mul_mask(s2_y_reg));
    end

    always_comb
    begin
        out_item_next.size = s3_size_reg;
        if (s3_mode_reg == chpi_pkg::MODE_STAR)
        begin
            out_item_next.hash = s3_x_reg ^ (s3_y_reg + chpi_pkg::GOLD + 64'd1);
        end
        else
        begin
            out_item_next.hash = (s3_x_reg + chpi_pkg::GOLD) ^ s3_y_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_mode_reg  <= mode;
            s1_x_reg     <= xor_shift(x_bits);
            s1_y_reg     <= xor_shift(y_bits);
            s1_size_reg  <= table_size;

            s2_mode_reg  <= s1_mode_reg;
            s2_x_reg     <= s2_x_next;
            s2_y_reg     <= s2_y_next;
            s2_size_reg  <= s1_size_reg;

            s3_mode_reg  <= s2_mode_reg;
            s3_x_reg     <= s3_x_next;
            s3_y_reg     <= s3_y_next;
            s3_size_reg  <= s2_size_reg;

            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* src/chpi_queue.sv */
`timescale 1ns / 1ps

module chpi_queue
#(
    parameter int DEPTH = chpi_pkg::QUEUE_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  chpi_pkg::hash_item_t     push_item,
    input  logic                     pop,
    output chpi_pkg::queue_status_t  status,
    output chpi_pkg::hash_item_t     head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    chpi_pkg::hash_item_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic                   do_push;
    logic                   do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push & ~status.full;
    assign do_pop       = pop & ~status.empty;
    assign head_item    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* src/chpi_divider.sv */
`timescale 1ns / 1ps

module chpi_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  chpi_pkg::hash_item_t          in_item,
    output logic                          done,
    output logic [chpi_pkg::SIZE_W-1:0]   slot_index
);

    localparam int N = chpi_pkg::DIV_STAGES;
    localparam int W = chpi_pkg::WORD_W;
    localparam int S = chpi_pkg::SIZE_W;

    logic           valid_reg  [N];
    logic [S-1:0]   rem_reg    [N];
    logic [W-1:0]   dvd_reg    [N];
    logic [S-1:0]   size_reg   [N];

    logic [S-1:0]   rem_next   [N];
    logic [W-1:0]   dvd_next   [N];
    logic [S-1:0]   size_next  [N];
    logic           valid_next [N];

    logic           done_reg;
    logic [S-1:0]   slot_index_reg;

    // one restoring step per stage, most significant dividend bit first
    always_comb
    begin
        logic [S-1:0] src_rem;
        logic [W-1:0] src_dvd;
        logic [S-1:0] src_size;
        logic [S:0]   trial;
        logic [S:0]   diff;
        for (int k = 0; k < N; k++)
        begin
            if (k == 0)
            begin
                src_rem       = '0;
                src_dvd       = in_item.hash;
                src_size      = in_item.size;
                valid_next[k] = in_valid;
            end
            else
            begin
                src_rem       = rem_reg[k-1];
                src_dvd       = dvd_reg[k-1];
                src_size      = size_reg[k-1];
                valid_next[k] = valid_reg[k-1];
            end
            trial = {src_rem, src_dvd[W-1]};
            diff  = trial - {1'b0, src_size};
            if (trial >= {1'b0, src_size})
            begin
                rem_next[k] = diff[S-1:0];
            end
            else
            begin
                rem_next[k] = trial[S-1:0];
            end
            dvd_next[k]  = src_dvd << 1;
            size_next[k] = src_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < N; k++)
            begin
                valid_reg[k] <= valid_next[k];
            end
            done_reg <= valid_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            dvd_reg[k]  <= dvd_next[k];
            size_reg[k] <= size_next[k];
        end
        // zero table size gives slot zero
        slot_index_reg <= (size_reg[N-1] == '0) ? '0 : rem_reg[N-1];
    end

    assign done       = done_reg;
    assign slot_index = slot_index_reg;

endmodule

/* src/coordinate_pair_hash_index_core.sv */
// the result strobe passes the front pipeline, the queue, the remainder pipeline and the
// output register in turn; throughput one request per cycle, set by the fully pipelined
// 64-stage remainder unit taking a new dividend every cycle
// busy rises only if the queue is full, which cannot happen since the receiver never stalls
// reset: asynchronous active low, clears all valid flags and queue pointers; no strobe follows
`timescale 1ns / 1ps

module coordinate_pair_hash_index_core
#(
    parameter int QUEUE_DEPTH = chpi_pkg::QUEUE_DEPTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          mode,
    input  logic [chpi_pkg::WORD_W-1:0]   x_bits,
    input  logic [chpi_pkg::WORD_W-1:0]   y_bits,
    input  logic [chpi_pkg::SIZE_W-1:0]   table_size,
    output logic                          done,
    output logic [chpi_pkg::SIZE_W-1:0]   slot_index
);

    // front to queue
    logic                        front_valid;
    chpi_pkg::hash_item_t        front_item;
    chpi_pkg::queue_status_t     queue_status;

    // queue to back
    chpi_pkg::hash_item_t        head_item;
    logic                        head_valid;

    // front: registers the request, mixes both words in three steps (an xor-shift,
    // then twice a shift-subtract for the 0xffffffff multiply plus xor-shift),
    // then combines by mode; stalls only while its output waits on a full queue
    chpi_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start),
        .mode         (mode),
        .x_bits       (x_bits),
        .y_bits       (y_bits),
        .table_size   (table_size),
        .queue_status (queue_status),
        .stall        (busy),
        .out_valid    (front_valid),
        .out_item     (front_item)
    );

    // short queue decoupling the hash front from the remainder back end
    chpi_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_item (front_item),
        .pop       (head_valid),
        .status    (queue_status),
        .head_item (head_item)
    );

    // the back end accepts every cycle, so any queued item is taken at once
    assign head_valid = ~queue_status.empty;

    // back: pipelined restoring remainder, one quotient bit per stage
    chpi_divider u_divider
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (head_valid),
        .in_item    (head_item),
        .done       (done),
        .slot_index (slot_index)
    );

endmodule

/* tb/sv/coordinate_pair_hash_index_checker.sv */
`timescale 1ns / 1ps

module coordinate_pair_hash_index_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          mode,
    input  logic [chpi_pkg::WORD_W-1:0]   x_bits,
    input  logic [chpi_pkg::WORD_W-1:0]   y_bits,
    input  logic [chpi_pkg::SIZE_W-1:0]   table_size,
    input  logic                          done,
    input  logic [chpi_pkg::SIZE_W-1:0]   slot_index,
    output int                            mismatch_count,
    output int                            slots_outstanding,
    output int                            slots_checked
);

    localparam int                          MIXER_RSHIFT = 33;
    localparam logic [chpi_pkg::WORD_W-1:0] MIXER_MUL    = 64'h0000_0000_ffff_ffff;
    localparam logic [chpi_pkg::WORD_W-1:0] GOLDEN_RATIO = 64'h9e37_79b9_7f4a_7c15;

    logic [chpi_pkg::SIZE_W-1:0] expected_slots[$];
    int                          fail_total    = 0;
    int                          checked_total = 0;

    assign mismatch_count    = fail_total;
    assign slots_outstanding = expected_slots.size();
    assign slots_checked     = checked_total;

    function automatic logic [chpi_pkg::WORD_W-1:0] mix_coord_word(
        input logic [chpi_pkg::WORD_W-1:0] w
    );
        logic [chpi_pkg::WORD_W-1:0] h;
        h = w ^ (w >> MIXER_RSHIFT);
        h = h * MIXER_MUL;
        h = h ^ (h >> MIXER_RSHIFT);
        h = h * MIXER_MUL;
        h = h ^ (h >> MIXER_RSHIFT);
        return h;
    endfunction

    function automatic logic [chpi_pkg::SIZE_W-1:0] predict_slot(
        input chpi_pkg::mode_t             m,
        input logic [chpi_pkg::WORD_W-1:0] xw,
        input logic [chpi_pkg::WORD_W-1:0] yw,
        input logic [chpi_pkg::SIZE_W-1:0] sz
    );
        logic [chpi_pkg::WORD_W-1:0] hx;
        logic [chpi_pkg::WORD_W-1:0] hy;
        logic [chpi_pkg::WORD_W-1:0] combined;
        logic [chpi_pkg::WORD_W-1:0] rem;
        hx = mix_coord_word(xw);
        hy = mix_coord_word(yw);
        case (m)
            chpi_pkg::MODE_GALAXY: combined = (hx + GOLDEN_RATIO) ^ hy;
            default:               combined = hx ^ (hy + GOLDEN_RATIO + 64'd1);
        endcase
        // zero size gives slot zero, no division
        if (sz == '0)
            return '0;
        rem = combined % {{(chpi_pkg::WORD_W-chpi_pkg::SIZE_W){1'b0}}, sz};
        return rem[chpi_pkg::SIZE_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: slot index error: %s", $time, msg);
        fail_total++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                expected_slots.push_back(predict_slot(chpi_pkg::mode_t'(mode), x_bits,
                                                      y_bits, table_size));
            if (done)
            begin
                if (expected_slots.size() == 0)
                    report_mismatch($sformatf("result %0d with no request pending",
                                              slot_index));
                else
                begin
                    if (slot_index !== expected_slots[0])
                        report_mismatch($sformatf("expected %0d, got %0d",
                                                  expected_slots[0], slot_index));
                    void'(expected_slots.pop_front());
                    checked_total++;
                end
            end
        end
    end

endmodule

/* tb/sv/coordinate_pair_hash_index_core_test.sv */
`timescale 1ns / 1ps

module coordinate_pair_hash_index_core_test;

    // settle time that covers the tail of the pipeline
    localparam int SETTLE_CYCLES  = 80;
    localparam int RANDOM_COUNT   = 550;
    // no idling in the last stretch of the random part
    localparam int CALM_FROM      = 450;
    // sender waits for every slot index here
    localparam int DRAIN_AT       = 275;
    localparam logic [chpi_pkg::SIZE_W-1:0] SIZE_MAX = 31'h7fff_ffff;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic                          mode;
    logic [chpi_pkg::WORD_W-1:0]   x_bits;
    logic [chpi_pkg::WORD_W-1:0]   y_bits;
    logic [chpi_pkg::SIZE_W-1:0]   table_size;
    logic                          done;
    logic [chpi_pkg::SIZE_W-1:0]   slot_index;

    int                  mismatch_count;
    int                  slots_outstanding;
    int                  slots_checked;

    // request tallies for the closing summary
    int                  star_requests   = 0;
    int                  galaxy_requests = 0;

    coordinate_pair_hash_index_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .x_bits     (x_bits),
        .y_bits     (y_bits),
        .table_size (table_size),
        .done       (done),
        .slot_index (slot_index)
    );

    // watches both sides, predicts every slot index and compares
    coordinate_pair_hash_index_checker slot_check
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .mode              (mode),
        .x_bits            (x_bits),
        .y_bits            (y_bits),
        .table_size        (table_size),
        .done              (done),
        .slot_index        (slot_index),
        .mismatch_count    (mismatch_count),
        .slots_outstanding (slots_outstanding),
        .slots_checked     (slots_checked)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // hard stop in case the block hangs or drops results
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // present one request at the falling edge and hold it until accepted;
    // start stays high so back-to-back requests need no extra assignment
    task automatic send_request(input chpi_pkg::mode_t m,
                                input logic [chpi_pkg::WORD_W-1:0] xw,
                                input logic [chpi_pkg::WORD_W-1:0] yw,
                                input logic [chpi_pkg::SIZE_W-1:0] sz);
        @(negedge clk);
        start      <= 1'b1;
        mode       <= m;
        x_bits     <= xw;
        y_bits     <= yw;
        table_size <= sz;
        // accepted at the first rising edge with busy low
        do
            @(posedge clk);
        while (busy);
        if (m == chpi_pkg::MODE_STAR)
            star_requests++;
        else
            galaxy_requests++;
    endtask

    // idle burst; the payload ports carry junk meanwhile, which must be ignored
    task automatic idle_sender(input int cycles);
        @(negedge clk);
        start      <= 1'b0;
        x_bits     <= {$urandom, $urandom};
        y_bits     <= {$urandom, $urandom};
        table_size <= chpi_pkg::SIZE_W'($urandom);
        mode       <= 1'($urandom_range(0, 1));
        repeat (cycles - 1) @(negedge clk);
    endtask

    // hold off until every slot index has come back
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (slots_outstanding != 0)
            @(negedge clk);
    endtask

    // coordinate words: mostly random patterns, some notable doubles and
    // small integers so the mixer sees sparse inputs too
    function automatic logic [chpi_pkg::WORD_W-1:0] pick_coord_word();
        logic [chpi_pkg::WORD_W-1:0] w;
        case ($urandom_range(0, 9))
            0:       w = 64'h3ff0_0000_0000_0000;      // 1.0
            1:       w = 64'h8000_0000_0000_0000;      // negative zero
            2:       w = 64'h7ff0_0000_0000_0000;      // infinity
            3:       w = {32'h0, $urandom_range(0, 255)};
            4:       w = {$urandom, 32'h0};
            5:       w = ~{$urandom, $urandom};
            default: w = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    // table sizes: some small, some powers of two, some at the extremes, the rest anywhere in range
    function automatic logic [chpi_pkg::SIZE_W-1:0] pick_table_size();
        logic [chpi_pkg::SIZE_W-1:0] sz;
        case ($urandom_range(0, 9))
            0, 1, 2: sz = chpi_pkg::SIZE_W'($urandom_range(1, 64));
            3, 4:    sz = 31'd1 << $urandom_range(0, 30);
            5:       sz = ($urandom_range(0, 1) == 1) ? SIZE_MAX : 31'd1;
            default: sz = chpi_pkg::SIZE_W'($urandom_range(1, 32'h7fff_ffff));
        endcase
        return sz;
    endfunction

    initial
    begin
        mode       = 1'b0;
        start      = 1'b0;
        x_bits     = '0;
        y_bits     = '0;
        table_size = '0;
        rst_n      = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, notable doubles, both forms, back to back
        send_request(chpi_pkg::MODE_STAR,   '0, '0, SIZE_MAX);
        send_request(chpi_pkg::MODE_GALAXY, '0, '0, SIZE_MAX);
        send_request(chpi_pkg::MODE_STAR,   '1, '1, SIZE_MAX);
        send_request(chpi_pkg::MODE_GALAXY, '1, '0, 31'd1);
        send_request(chpi_pkg::MODE_STAR,   '0, '1, 31'd1);
        send_request(chpi_pkg::MODE_STAR,   64'h3ff0_0000_0000_0000,
                     64'hbff0_0000_0000_0000, 31'd1000);
        send_request(chpi_pkg::MODE_GALAXY, 64'h8000_0000_0000_0000, 64'h0, 31'd1000);
        send_request(chpi_pkg::MODE_STAR,   64'h7ff0_0000_0000_0000,
                     64'hfff0_0000_0000_0000, 31'h4000_0000);
        send_request(chpi_pkg::MODE_GALAXY, 64'h7ff8_0000_0000_0000,
                     64'h7fef_ffff_ffff_ffff, 31'h4000_0000);
        send_request(chpi_pkg::MODE_STAR,   64'h1, 64'h1, 31'd2);
        send_request(chpi_pkg::MODE_GALAXY, 64'h5555_5555_5555_5555,
                     64'haaaa_aaaa_aaaa_aaaa, SIZE_MAX);
        send_request(chpi_pkg::MODE_STAR,   64'haaaa_aaaa_aaaa_aaaa,
                     64'h5555_5555_5555_5555, 31'd12345);
        // identical coordinates in both forms
        send_request(chpi_pkg::MODE_STAR,   64'h4009_21fb_5444_2d18,
                     64'h4009_21fb_5444_2d18, 31'd997);
        send_request(chpi_pkg::MODE_GALAXY, 64'h4009_21fb_5444_2d18,
                     64'h4009_21fb_5444_2d18, 31'd3);
        send_request(chpi_pkg::MODE_GALAXY, {$urandom, $urandom}, {$urandom, $urandom},
                     SIZE_MAX - 31'd1);
        // zero table size must give slot zero
        send_request(chpi_pkg::MODE_STAR,   {$urandom, $urandom}, {$urandom, $urandom}, '0);
        send_request(chpi_pkg::MODE_GALAXY, '1, '1, '0);
        idle_sender(2);

        // random part: idle bursts early on, one full drain mid-run,
        // and a dense back-to-back stretch at the end
        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            if (i == DRAIN_AT)
                drain_results();
            else if (i < CALM_FROM && $urandom_range(0, 3) == 0)
                idle_sender($urandom_range(1, 3));
            send_request(chpi_pkg::mode_t'($urandom_range(0, 1)), pick_coord_word(),
                         pick_coord_word(), pick_table_size());
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("covered %0d star-form and %0d galaxy-form requests, sizes 0 to 2^31-1",
                 star_requests, galaxy_requests);
        $display("%0d slot indexes compared, %0d errors", slots_checked, mismatch_count);
        if (mismatch_count == 0 && slots_outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
